// ----- design/sitda_pkg.sv -----
// Shared types, constants and the power-of-ten table for the decimal text converter.
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IDX_W           = 5;   // digit position, up to 19 digits at 64 bits
    localparam int POW_W           = 68;  // table entry width
    localparam int DIGIT_W         = 4;
    localparam int TRIAL_W         = 2;   // trial bit index inside one digit

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic               load;
        logic               emit_sign;
        logic               scale_up;
        logic               clear_digit;
        logic               trial;
        logic [TRIAL_W-1:0] trial_bit;
        logic               emit_digit;
        logic               next_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic scale_more;
        logic last_pos;
        logic out_free;
    } sts_t;

    function automatic logic [POW_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [POW_W-1:0] p;
        unique case (idx)
            5'd0:    p = 68'd1;
            5'd1:    p = 68'd10;
            5'd2:    p = 68'd100;
            5'd3:    p = 68'd1000;
            5'd4:    p = 68'd10000;
            5'd5:    p = 68'd100000;
            5'd6:    p = 68'd1000000;
            5'd7:    p = 68'd10000000;
            5'd8:    p = 68'd100000000;
            5'd9:    p = 68'd1000000000;
            5'd10:   p = 68'd10000000000;
            5'd11:   p = 68'd100000000000;
            5'd12:   p = 68'd1000000000000;
            5'd13:   p = 68'd10000000000000;
            5'd14:   p = 68'd100000000000000;
            5'd15:   p = 68'd1000000000000000;
            5'd16:   p = 68'd10000000000000000;
            5'd17:   p = 68'd100000000000000000;
            5'd18:   p = 68'd1000000000000000000;
            5'd19:   p = 68'd10000000000000000000;
            default: p = '1;  // out of range: larger than any magnitude
        endcase
        return p;
    endfunction

endpackage

// ----- design/sitda_ctrl.sv -----
// Sequencer: sign, scaling, per-digit restoring trials and character emission.
module sitda_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sitda_pkg::sts_t sts,
    output sitda_pkg::cmd_t cmd
);
    import sitda_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SIGN  = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_TRIAL = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [TRIAL_W-1:0] bit_reg, bit_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.trial_bit = bit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!sts.neg)
                begin
                    state_next = ST_SCALE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (sts.scale_more)
                begin
                    cmd.scale_up = 1'b1;
                end
                else
                begin
                    cmd.clear_digit = 1'b1;
                    bit_next        = '1;
                    state_next      = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                cmd.trial = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_EMIT;
                else
                    bit_next = bit_reg - TRIAL_W'(1);
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.last_pos)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_digit = 1'b1;
                        bit_next       = '1;
                        state_next     = ST_TRIAL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ----- design/sitda_dp.sv -----
// Datapath: magnitude, digit position, trial subtractor and output register.
module sitda_dp #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  sitda_pkg::cmd_t               cmd,
    output sitda_pkg::sts_t               sts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_code,
    output logic                          last_char
);
    import sitda_pkg::*;

    localparam int DIV_W = VALUE_WIDTH + 4;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [DIGIT_W-1:0]     digit_reg, digit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;

    logic [VALUE_WIDTH-1:0] val_u;
    logic [DIV_W-1:0]       mag_ext;
    logic [DIV_W-1:0]       pow_next_digit;
    logic [DIV_W-1:0]       trial_div;
    logic                   fit;

    assign val_u          = value;
    assign mag_ext        = DIV_W'(mag_reg);
    assign pow_next_digit = DIV_W'(pow10(idx_reg + IDX_W'(1)));
    // 8, 4, 2 or 1 times the current power of ten
    assign trial_div      = DIV_W'(pow10(idx_reg)) << cmd.trial_bit;
    assign fit            = (mag_ext >= trial_div);

    assign sts.neg        = neg_reg;
    assign sts.scale_more = (mag_ext >= pow_next_digit);
    assign sts.last_pos   = (idx_reg == '0);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        digit_next = digit_reg;
        if (cmd.load)
        begin
            // most negative value wraps to 2^(W-1), correct as unsigned
            neg_next = val_u[VALUE_WIDTH-1];
            mag_next = val_u[VALUE_WIDTH-1] ? (~val_u + VALUE_WIDTH'(1)) : val_u;
            idx_next = '0;
        end
        if (cmd.scale_up)
            idx_next = idx_reg + IDX_W'(1);
        if (cmd.clear_digit)
            digit_next = '0;
        if (cmd.trial && fit)
        begin
            mag_next                  = mag_reg - VALUE_WIDTH'(trial_div);
            digit_next[cmd.trial_bit] = 1'b1;
        end
        if (cmd.next_digit)
        begin
            idx_next   = idx_reg - IDX_W'(1);
            digit_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = CH_MINUS;
            last_next      = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = CH_ZERO + {4'b0000, digit_reg};
            last_next      = (idx_reg == '0);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            idx_reg       <= '0;
            mag_reg       <= '0;
            digit_reg     <= '0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            idx_reg       <= idx_next;
            mag_reg       <= mag_next;
            digit_reg     <= digit_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // a held character must never be overwritten
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
        else $error("character emitted into a held output slot");

    // scaling must leave the magnitude below ten times the current position
    a_trial_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trial |-> !sts.scale_more)
        else $error("digit trial started with magnitude out of range");

    // nothing may remain once the units digit goes out
    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && sts.last_pos) |-> (mag_reg == '0))
        else $error("remainder left after the final digit");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == CH_MINUS ||
                           (char_reg >= CH_ZERO && char_reg <= CH_ZERO + 8'd9)))
        else $error("output character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_reg == CH_MINUS) |-> !last_reg)
        else $error("minus sign flagged as final character");

endmodule

// ----- design/signed_int_to_decimal_ascii.sv -----
// Top level: signed integer to decimal ASCII text converter.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    value (VALUE_WIDTH, signed)
//  output    out        out_valid / out_stall  char_code (8), last_char (1)
//
//  One number at a time; in_stall is high from acceptance until the last
//  character has been placed in the output register.
//  Steps per number: accept, a sign step (the minus goes out here when
//  negative), scaling steps up to the leading digit and one exit step,
//  then per digit 4 restoring trials against 8x/4x/2x/1x the power of
//  ten and one emit step, most significant digit first.
//  All trials share the single trial subtractor and the power-of-ten table.
//  Output stalls hold the sequencer at the sign or emit step; no data is lost.
//  Reset (rst_n low, asynchronous) returns to idle with the output empty.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    char_code,
    output logic                          last_char
);
    import sitda_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sitda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sitda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
// Testbench for the signed integer to decimal ASCII text converter.
module tb_signed_int_to_decimal_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;

    localparam int W              = VALUE_WIDTH_DEF;
    localparam int DIR_ITEMS      = 20;
    localparam int RAND_ITEMS     = 190;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [W-1:0]  value;
    logic                 out_valid;
    logic                 out_stall;
    logic [7:0]           char_code;
    logic                 last_char;

    text_char_t text_expected[$];
    int         mismatch_count;
    int         numbers_accepted;
    int         chars_received;
    bit         sender_done;
    bit         hold_long;

    // Directed table; an empty text means the predictor fills in the expectation.
    logic [W-1:0] dir_value [DIR_ITEMS] = '{
        32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h00000009, 32'h0000000A,
        32'hFFFFFFF6, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000,
        32'd999999999, 32'd100, 32'd12345, 32'hC521974F, 32'h55555555,
        32'hAAAAAAAA, 32'd1999999999, 32'hC4653600, 32'd7, 32'hFFFFFFFB
    };
    string dir_text [DIR_ITEMS] = '{
        "0", "1", "-1", "9", "10",
        "-10", "2147483647", "-2147483648", "-2147483647", "1000000000",
        "999999999", "", "", "", "",
        "", "", "", "", ""
    };

    signed_int_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Sign first, then digits of the magnitude, most significant first.
    task automatic push_decimal_text(input logic [W-1:0] v);
        logic [W-1:0] mag;
        logic [63:0]  rest;
        logic [63:0]  scale;
        logic [63:0]  digit;
        begin
            if (v[W-1])
            begin
                text_expected.push_back('{CH_MINUS, 1'b0});
                mag = ~v + W'(1);  // most negative value wraps to 2^(W-1), read unsigned
            end
            else
            begin
                mag = v;
            end
            rest  = 64'(mag);
            scale = 64'd1;
            while (rest / scale > 64'd9)
                scale = scale * 64'd10;
            while (scale != 64'd0)
            begin
                digit = rest / scale;
                rest  = rest % scale;
                scale = scale / 64'd10;
                text_expected.push_back('{8'(CH_ZERO + digit[7:0]), scale == 64'd0});
            end
        end
    endtask

    function automatic logic [W-1:0] rand_value();
        logic [W-1:0] v;
        int unsigned  k;
        logic [W-1:0] p;
        begin
            case ($urandom_range(0, 4)) inside
                [0:1]:
                begin
                    v = $urandom;
                end
                2:
                begin
                    v = $urandom_range(0, 999);
                end
                3:
                begin
                    // around a power of ten
                    k = $urandom_range(0, 9);
                    p = 1;
                    repeat (k) p = p * 10;
                    v = p + $urandom_range(0, 2) - 1;
                end
                default:
                begin
                    v = 32'h7FFFFFFF - $urandom_range(0, 15);
                end
            endcase
            if ($urandom_range(0, 1) == 1)
                v = ~v + W'(1);
            return v;
        end
    endfunction

    function automatic int sender_gap(input int idx);
        begin
            if ((idx / 40) % 4 == 3)
                return 0;
            return $urandom_range(0, 10);
        end
    endfunction

    function automatic void report_failure(input string msg);
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%s", msg);
        end
    endfunction

    // Sender: offers numbers, holds the payload until the transfer.
    initial
    begin
        logic [W-1:0] v;
        int           gap;
        string        txt;
        in_valid    = 1'b0;
        value       = '0;
        sender_done = 1'b0;
        numbers_accepted = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        for (int i = 0; i < DIR_ITEMS + RAND_ITEMS; i++)
        begin
            if (i < DIR_ITEMS)
            begin
                v   = dir_value[i];
                txt = dir_text[i];
            end
            else
            begin
                v   = rand_value();
                txt = "";
            end
            gap = sender_gap(i);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            value    <= v;
            do @(posedge clk); while (in_stall !== 1'b0);
            if (txt.len() == 0)
            begin
                push_decimal_text(v);
            end
            else
            begin
                for (int c = 0; c < txt.len(); c++)
                    text_expected.push_back('{8'(txt[c]), c == txt.len() - 1});
            end
            numbers_accepted++;
            @(negedge clk);
        end
        in_valid    <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver: random stalls per character, plus one long hold-off.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = ((chars_received / 50) % 4 == 3) ? 0 : $urandom_range(0, 10);
            while (gap > 0 || hold_long)
            begin
                out_stall <= 1'b1;
                if (gap > 0)
                    gap--;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        hold_long = 1'b0;
        while (numbers_accepted < HOLD_AFTER)
            @(posedge clk);
        @(posedge clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
    end

    // Check each character transfer against the oldest expectation.
    initial
    begin
        text_char_t want;
        mismatch_count = 0;
        chars_received = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                chars_received++;
                if (text_expected.size() == 0)
                begin
                    report_failure($sformatf("unexpected char: code=%h last=%b",
                                             char_code, last_char));
                end
                else
                begin
                    want = text_expected.pop_front();
                    if (char_code !== want.code || last_char !== want.last)
                        report_failure($sformatf(
                            "mismatch at char %0d: expected code=%h last=%b, got code=%h last=%b",
                            chars_received, want.code, want.last, char_code, last_char));
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (sender_done);
        while (text_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && text_expected.size() == 0)
            $display("** signed_int_to_decimal_ascii: PASSED **");
        else
            $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sitda_pkg.sv
design/sitda_ctrl.sv
design/sitda_dp.sv
design/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
